// ----- design/gcbp_pkg.sv -----
`default_nettype none

package gcbp_pkg;

  // Input field widths
  localparam int VAL_W  = 16;
  localparam int BLEN_W = 5;
  localparam int ULEN_W = 6;

  // Widened length arithmetic (holds blen + ulen without overflow)
  localparam int LSUM_W = 7;

  // A code longer than this is rejected
  localparam int CODE_CAP = 64;

  localparam int BYTE_W = 8;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 4;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_FLUSH  = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

// ----- design/gcbp_front.sv -----
`default_nettype none

module gcbp_front import gcbp_pkg::*; #(
  parameter int MAX_BINARY_BITS = 16,
  parameter int MAX_UNARY_BITS  = 48,
  parameter int WORD_W          = 72,
  parameter int NB_W            = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic              q_full,
  input  wire logic              in_opcode,
  input  wire logic [VAL_W-1:0]  in_binary_value,
  input  wire logic [BLEN_W-1:0] in_binary_length,
  input  wire logic [ULEN_W-1:0] in_unary_length,
  output logic                   enq,
  output logic [WORD_W-1:0]      enq_word,
  output logic [NB_W-1:0]        enq_nbytes,
  output logic                   enq_err
);

  localparam logic [LSUM_W-1:0] MB  = LSUM_W'(MAX_BINARY_BITS);
  localparam logic [LSUM_W-1:0] MU  = LSUM_W'(MAX_UNARY_BITS);
  localparam logic [LSUM_W-1:0] CAP = LSUM_W'(CODE_CAP);
  localparam logic [7:0]        WW  = 8'(WORD_W);

  logic [BYTE_W-1:0] pb_r, pb_nxt;   // partial byte, filled from bit 7
  logic [2:0]        pc_r, pc_nxt;   // bits held in pb_r

  logic              accept;
  logic              is_flush;
  logic [LSUM_W-1:0] blen_w, ulen_w, code_len;
  logic              len_err;
  logic [7:0]        total, bin_sh, one_sh;
  logic [VAL_W:0]    mask_ext;
  logic [VAL_W-1:0]  bval;
  logic [WORD_W-1:0] head, word, rest;
  logic [NB_W-1:0]   nbytes;

  assign accept   = push && !q_full;
  assign is_flush = (opcode_t'(in_opcode) == OP_FLUSH);

  always_comb begin
    blen_w   = {{(LSUM_W-BLEN_W){1'b0}}, in_binary_length};
    ulen_w   = {{(LSUM_W-ULEN_W){1'b0}}, in_unary_length};
    code_len = blen_w + ulen_w;
    len_err  = (blen_w > MB) || (ulen_w > MU) || (ulen_w == '0) || (code_len > CAP);

    // pending bits, then binary bits MSB first, then zeros and the stop one
    total    = {5'b0, pc_r} + {{(8-LSUM_W){1'b0}}, code_len};
    bin_sh   = WW - {5'b0, pc_r} - {{(8-LSUM_W){1'b0}}, blen_w};
    one_sh   = WW - total;
    mask_ext = ({{VAL_W{1'b0}}, 1'b1} << in_binary_length) - {{VAL_W{1'b0}}, 1'b1};
    bval     = in_binary_value & mask_ext[VAL_W-1:0];
    head     = {pb_r, {(WORD_W-BYTE_W){1'b0}}};
    word     = head
             | (WORD_W'(bval) << bin_sh)
             | ({{(WORD_W-1){1'b0}}, 1'b1} << one_sh);
    nbytes   = NB_W'(total >> 3);
    rest     = word << {nbytes, 3'b000};

    pb_nxt     = pb_r;
    pc_nxt     = pc_r;
    enq        = 1'b0;
    enq_word   = word;
    enq_nbytes = nbytes;
    enq_err    = 1'b0;

    if (is_flush) begin
      enq_word   = head;
      enq_nbytes = NB_W'(1);
      enq        = accept && (pc_r != '0);
      if (accept) begin
        pb_nxt = '0;
        pc_nxt = '0;
      end
    end else if (len_err) begin
      // rejected: one error result, state untouched
      enq_word   = '0;
      enq_nbytes = NB_W'(1);
      enq_err    = 1'b1;
      enq        = accept;
    end else begin
      enq = accept && (nbytes != '0);
      if (accept) begin
        pb_nxt = rest[WORD_W-1 -: BYTE_W];
        pc_nxt = total[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r <= '0;
      pc_r <= '0;
    end else begin
      pb_r <= pb_nxt;
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/gcbp_fifo.sv -----
`default_nettype none

module gcbp_fifo import gcbp_pkg::*; #(
  parameter int WIDTH = 77,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/gcbp_back.sv -----
`default_nettype none

module gcbp_back import gcbp_pkg::*; #(
  parameter int WORD_W = 72,
  parameter int NB_W   = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire logic [WORD_W-1:0] q_word,
  input  wire logic [NB_W-1:0]   q_nbytes,
  input  wire logic              q_err,
  output logic                   q_pop,
  output logic                   empty,
  input  wire logic              pop,
  output logic [BYTE_W-1:0]      out_packed_byte,
  output logic                   out_last_of_item,
  output logic                   out_length_error
);

  logic              busy_r, busy_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [NB_W-1:0]   left_r, left_nxt;
  logic              err_r, err_nxt;

  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              oe_r, oe_nxt;

  logic              out_take, emit, last_byte;

  assign empty            = !ov_r;
  assign out_packed_byte  = ob_r;
  assign out_last_of_item = ol_r;
  assign out_length_error = oe_r;

  always_comb begin
    out_take  = !ov_r || pop;
    emit      = busy_r && out_take;
    last_byte = (left_r == NB_W'(1));
    q_pop     = !q_empty && (!busy_r || (emit && last_byte));

    busy_nxt = busy_r;
    word_nxt = word_r;
    left_nxt = left_r;
    err_nxt  = err_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    oe_nxt   = oe_r;

    if (emit) begin
      ov_nxt   = 1'b1;
      ob_nxt   = word_r[WORD_W-1 -: BYTE_W];
      ol_nxt   = last_byte;
      oe_nxt   = err_r;
      word_nxt = word_r << BYTE_W;
      left_nxt = left_r - NB_W'(1);
      if (last_byte) begin
        busy_nxt = 1'b0;
      end
    end else if (out_take) begin
      ov_nxt = 1'b0;
    end

    if (q_pop) begin
      busy_nxt = 1'b1;
      word_nxt = q_word;
      left_nxt = q_nbytes;
      err_nxt  = q_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    left_r <= left_nxt;
    err_r  <= err_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
    oe_r   <= oe_nxt;
  end

endmodule

`default_nettype wire

// ----- design/golomb_code_bit_packer.sv -----
// Path: a byte passes the queue, the byte unit's word and then the output register.
// Throughput: one request per cycle in while full is low; one byte per cycle out while
//   pop keeps up. A request holds the byte unit until its last byte goes out; a 4-entry
//   queue absorbs bursts, full rises when it fills.
// Reset: synchronous, active-low rst_n; clears the partial byte, empties the queue and
//   the output register.
`default_nettype none

module golomb_code_bit_packer import gcbp_pkg::*; #(
  parameter int MAX_BINARY_BITS = 16,
  parameter int MAX_UNARY_BITS  = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request side
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_opcode,
  input  wire logic [VAL_W-1:0]  in_binary_value,
  input  wire logic [BLEN_W-1:0] in_binary_length,
  input  wire logic [ULEN_W-1:0] in_unary_length,
  // byte side
  output logic                   empty,
  input  wire logic              pop,
  output logic [BYTE_W-1:0]      out_packed_byte,
  output logic                   out_last_of_item,
  output logic                   out_length_error
);

  // Longest code that passes the length checks. The binary length port tops out at 31
  // and the unary one at 63; anything over CODE_CAP is rejected anyway.
  localparam int BIN_EFF  = (MAX_BINARY_BITS < 31) ? MAX_BINARY_BITS : 31;
  localparam int UN_EFF   = (MAX_UNARY_BITS < 63) ? MAX_UNARY_BITS : 63;
  localparam int CODE_MAX = (BIN_EFF + UN_EFF < CODE_CAP) ? BIN_EFF + UN_EFF : CODE_CAP;
  // Working word: up to 7 pending bits plus the longest code, rounded up to bytes.
  localparam int WORD_W   = ((CODE_MAX + 7 + BYTE_W - 1) / BYTE_W) * BYTE_W;
  localparam int NB_W     = $clog2(WORD_W / BYTE_W + 1);
  // Queue entry: {error, byte count, left-aligned bit word}
  localparam int ENTRY_W  = WORD_W + NB_W + 1;

  logic              enq, enq_err;
  logic [WORD_W-1:0] enq_word;
  logic [NB_W-1:0]   enq_nbytes;

  logic              q_full, q_empty, q_pop;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  assign full    = q_full;
  assign q_wdata = {enq_err, enq_nbytes, enq_word};

  // Front: holds the partial byte, combinationally merges each code into a left-aligned
  // word and decides how many whole bytes the request yields. Requests that yield
  // nothing (short code, empty flush) never reach the queue.
  gcbp_front #(
    .MAX_BINARY_BITS (MAX_BINARY_BITS),
    .MAX_UNARY_BITS  (MAX_UNARY_BITS),
    .WORD_W          (WORD_W),
    .NB_W            (NB_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .q_full           (q_full),
    .in_opcode        (in_opcode),
    .in_binary_value  (in_binary_value),
    .in_binary_length (in_binary_length),
    .in_unary_length  (in_unary_length),
    .enq              (enq),
    .enq_word         (enq_word),
    .enq_nbytes       (enq_nbytes),
    .enq_err          (enq_err)
  );

  // Decouples the combinational front from the byte-at-a-time back.
  gcbp_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (enq),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: shifts bytes out of the current entry into the output register, one per cycle
  // while pop keeps up; loads the next entry in the same cycle the last byte goes out.
  gcbp_back #(
    .WORD_W (WORD_W),
    .NB_W   (NB_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_word           (q_rdata[WORD_W-1:0]),
    .q_nbytes         (q_rdata[WORD_W +: NB_W]),
    .q_err            (q_rdata[ENTRY_W-1]),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_packed_byte  (out_packed_byte),
    .out_last_of_item (out_last_of_item),
    .out_length_error (out_length_error)
  );

endmodule

`default_nettype wire

// ----- design/gcbp_checker.sv -----
`default_nettype none

module gcbp_checker import gcbp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              push,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [BYTE_W-1:0] out_packed_byte,
  input wire logic              out_last_of_item,
  input wire logic              out_length_error
);

  // reset empties the byte side and frees the request side
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("byte side not empty after reset");

  a_rst_free: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("full after reset");

  // a rejected code is a single zero byte that closes its request
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_length_error) |-> (out_last_of_item && out_packed_byte == '0))
    else $error("error result malformed");

  // a waiting byte holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_packed_byte) && $stable(out_last_of_item)))
    else $error("waiting byte changed");

endmodule

bind golomb_code_bit_packer gcbp_checker u_gcbp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .push             (push),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_packed_byte  (out_packed_byte),
  .out_last_of_item (out_last_of_item),
  .out_length_error (out_length_error)
);

`default_nettype wire

// ----- dv/gcbp_stream_checker.sv -----
`default_nettype none

module gcbp_stream_checker import gcbp_pkg::*; #(
  parameter int MAX_BINARY_BITS = 16,
  parameter int MAX_UNARY_BITS  = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic              full,
  input  wire logic              in_opcode,
  input  wire logic [VAL_W-1:0]  in_binary_value,
  input  wire logic [BLEN_W-1:0] in_binary_length,
  input  wire logic [ULEN_W-1:0] in_unary_length,
  input  wire logic              empty,
  input  wire logic              pop,
  input  wire logic [BYTE_W-1:0] out_packed_byte,
  input  wire logic              out_last_of_item,
  input  wire logic              out_length_error,
  output int                     fail_count,
  output int                     exp_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_item;
    logic              length_error;
  } byte_result_t;

  byte_result_t      expected_bytes[$];
  logic [BYTE_W-1:0] acc_bits;
  int unsigned       acc_count;

  initial begin
    fail_count  = 0;
    exp_pending = 0;
    acc_bits    = '0;
    acc_count   = 0;
  end

  // Appends one code (or flushes) and queues the bytes it completes.
  function automatic void pack_code(opcode_t op, logic [VAL_W-1:0] val,
                                    logic [BLEN_W-1:0] blen, logic [ULEN_W-1:0] ulen);
    bit           code_bits[$];
    byte_result_t made[$];
    byte_result_t r;
    if (op == OP_FLUSH) begin
      if (acc_count != 0) begin
        r = '{acc_bits, 1'b1, 1'b0};
        expected_bytes.push_back(r);
      end
      acc_bits  = '0;
      acc_count = 0;
      return;
    end
    // rejected code: one flagged byte, state untouched
    if (blen > MAX_BINARY_BITS || ulen > MAX_UNARY_BITS || ulen == 0 ||
        int'(blen) + int'(ulen) > CODE_CAP) begin
      r = '{'0, 1'b1, 1'b1};
      expected_bytes.push_back(r);
      return;
    end
    for (int i = int'(blen) - 1; i >= 0; i--) code_bits.push_back(val[i]);
    for (int i = 1; i < int'(ulen); i++) code_bits.push_back(1'b0);
    code_bits.push_back(1'b1);
    foreach (code_bits[i]) begin
      acc_bits[BYTE_W - 1 - acc_count] = code_bits[i];
      acc_count++;
      if (acc_count == BYTE_W) begin
        r = '{acc_bits, 1'b0, 1'b0};
        made.push_back(r);
        acc_bits  = '0;
        acc_count = 0;
      end
    end
    if (made.size() > 0) made[made.size() - 1].last_of_item = 1'b1;
    foreach (made[i]) expected_bytes.push_back(made[i]);
  endfunction

  always @(posedge clk) begin
    byte_result_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      acc_bits  = '0;
      acc_count = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $error("packed_byte: expected none, actual %02h", out_packed_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_packed_byte !== want.packed_byte) begin
            $error("packed_byte: expected %02h, actual %02h", want.packed_byte,
                   out_packed_byte);
            fail_count++;
          end
          if (out_last_of_item !== want.last_of_item) begin
            $error("last_of_item: expected %0b, actual %0b", want.last_of_item,
                   out_last_of_item);
            fail_count++;
          end
          if (out_length_error !== want.length_error) begin
            $error("length_error: expected %0b, actual %0b", want.length_error,
                   out_length_error);
            fail_count++;
          end
        end
      end
      if (push && !full)
        pack_code(opcode_t'(in_opcode), in_binary_value, in_binary_length, in_unary_length);
    end
    exp_pending <= expected_bytes.size();
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcbp_pkg::*;

  localparam int MAX_B = 16;
  localparam int MAX_U = 48;

  logic              clk              = 1'b0;
  logic              rst_n            = 1'b0;
  logic              push             = 1'b0;
  logic              in_opcode        = 1'b0;
  logic [VAL_W-1:0]  in_binary_value  = '0;
  logic [BLEN_W-1:0] in_binary_length = '0;
  logic [ULEN_W-1:0] in_unary_length  = 6'd1;
  logic              pop              = 1'b0;
  logic              full;
  logic              empty;
  logic [BYTE_W-1:0] out_packed_byte;
  logic              out_last_of_item;
  logic              out_length_error;

  int fail_count;
  int exp_pending;

  // run phase flags, all written by the stimulus process
  bit calm       = 1'b0;  // last stretch: no idling on either side
  bit burst      = 1'b0;  // sender offers back to back while the receiver holds off
  bit hold_asked = 1'b0;  // asks the receiver for one long hold-off

  golomb_code_bit_packer #(
    .MAX_BINARY_BITS(MAX_B),
    .MAX_UNARY_BITS (MAX_U)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_opcode       (in_opcode),
    .in_binary_value (in_binary_value),
    .in_binary_length(in_binary_length),
    .in_unary_length (in_unary_length),
    .empty           (empty),
    .pop             (pop),
    .out_packed_byte (out_packed_byte),
    .out_last_of_item(out_last_of_item),
    .out_length_error(out_length_error)
  );

  gcbp_stream_checker #(
    .MAX_BINARY_BITS(MAX_B),
    .MAX_UNARY_BITS (MAX_U)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_opcode       (in_opcode),
    .in_binary_value (in_binary_value),
    .in_binary_length(in_binary_length),
    .in_unary_length (in_unary_length),
    .empty           (empty),
    .pop             (pop),
    .out_packed_byte (out_packed_byte),
    .out_last_of_item(out_last_of_item),
    .out_length_error(out_length_error),
    .fail_count      (fail_count),
    .exp_pending     (exp_pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: ~260 requests of up to 8 bytes with random pop stalls end far below this.
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one request and hold it until the edge that takes it (push high, full low).
  // full is read right after the edge, so it is still the pre-edge value.
  task automatic send_req(opcode_t op, logic [VAL_W-1:0] val,
                          logic [BLEN_W-1:0] blen, logic [ULEN_W-1:0] ulen);
    push             <= 1'b1;
    in_opcode        <= op;
    in_binary_value  <= val;
    in_binary_length <= blen;
    in_unary_length  <= ulen;
    do @(posedge clk); while (full);
  endtask

  // Request, sometimes followed by a random idle burst on the sender side.
  task automatic offer(opcode_t op, logic [VAL_W-1:0] val,
                       logic [BLEN_W-1:0] blen, logic [ULEN_W-1:0] ulen);
    send_req(op, val, blen, ulen);
    if (!calm && !burst && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Sender goes quiet until every predicted byte has been popped.
  // exp_pending is registered, so let it catch up first; an idle tail follows the drain.
  task automatic wait_drained();
    push <= 1'b0;
    repeat (2) @(posedge clk);
    while (exp_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mostly well-formed appends with short unary parts so bytes stay frequent;
  // some flushes with junk fields, some rejected lengths.
  task automatic send_random_item();
    int                r;
    logic [VAL_W-1:0]  val;
    logic [BLEN_W-1:0] blen;
    logic [ULEN_W-1:0] ulen;
    r    = $urandom_range(0, 99);
    val  = VAL_W'($urandom);
    blen = BLEN_W'($urandom_range(0, 31));
    ulen = ULEN_W'($urandom_range(0, 63));
    if (r < 74) begin
      blen = BLEN_W'($urandom_range(0, MAX_B));
      ulen = ($urandom_range(0, 4) == 0) ? ULEN_W'($urandom_range(1, MAX_U))
                                         : ULEN_W'($urandom_range(1, 8));
      offer(OP_APPEND, val, blen, ulen);
    end else if (r < 88) begin
      offer(OP_FLUSH, val, blen, ulen);
    end else begin
      case ($urandom_range(0, 2))
        0: blen = BLEN_W'($urandom_range(MAX_B + 1, 31));
        1: ulen = '0;
        default: ulen = ULEN_W'($urandom_range(MAX_U + 1, 63));
      endcase
      offer(OP_APPEND, val, blen, ulen);
    end
  endtask

  // Receiver: random pop bursts, one long hold-off on request, steady pop at the end.
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_asked && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (80) @(posedge clk);
      end else if (calm) begin
        pop <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty flush with junk fields, then the corners
    offer(OP_FLUSH,  16'hFFFF, 5'd31, 6'd63);   // nothing pending: no byte
    offer(OP_APPEND, 16'h0000, 5'd0,  6'd1);    // shortest code, a lone one bit
    offer(OP_FLUSH,  16'h0000, 5'd0,  6'd0);    // partial byte 80
    offer(OP_APPEND, 16'hFFFF, 5'd16, 6'd48);   // longest code, eight bytes
    offer(OP_APPEND, 16'h0000, 5'd0,  6'd48);
    offer(OP_APPEND, 16'hFFF0, 5'd4,  6'd1);    // bits above the length ignored
    offer(OP_APPEND, 16'h1234, 5'd17, 6'd5);    // binary length too long
    offer(OP_APPEND, 16'hFFFF, 5'd31, 6'd1);
    offer(OP_APPEND, 16'h00FF, 5'd3,  6'd0);    // zero unary length
    offer(OP_APPEND, 16'h0001, 5'd1,  6'd49);   // unary length too long
    offer(OP_APPEND, 16'hFFFF, 5'd16, 6'd63);
    offer(OP_APPEND, 16'h8001, 5'd16, 6'd1);
    offer(OP_APPEND, 16'h0000, 5'd16, 6'd16);
    offer(OP_APPEND, 16'hA5A5, 5'd8,  6'd7);
    offer(OP_FLUSH,  16'h5A5A, 5'd16, 6'd48);
    offer(OP_FLUSH,  16'h0000, 5'd0,  6'd1);    // second flush in a row: no byte
    offer(OP_APPEND, 16'h0001, 5'd1,  6'd48);
    offer(OP_APPEND, 16'h7FFF, 5'd15, 6'd2);
    offer(OP_FLUSH,  16'h0000, 5'd0,  6'd0);
    offer(OP_APPEND, 16'hFFFF, 5'd0,  6'd8);    // value unused at zero length
    offer(OP_APPEND, 16'h0003, 5'd2,  6'd5);    // seven bits: no byte, all left pending
    offer(OP_FLUSH,  16'h0000, 5'd0,  6'd0);

    for (int n = 0; n < 230; n++) begin
      // receiver holds off while the sender keeps offering: fills the queue
      if (n == 50) begin
        hold_asked <= 1'b1;
        burst      <= 1'b1;
      end
      if (n == 80) burst <= 1'b0;
      if (n == 120) wait_drained();
      if (n == 190) calm <= 1'b1;
      send_random_item();
    end

    wait_drained();
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
